[rtl/core/msort_pkg.sv]
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and constants for the merge sorter and its cell row.
// ----------------------------------------------------------------------------
package msort_pkg;

    // element width and default row length
    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 64;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } cell_op_t;

    // broadcast control from the top level to the row
    typedef struct packed {
        cell_op_t                   op;
        logic signed [DATA_W-1:0]   din;
    } cell_ctl_t;

endpackage

[rtl/core/msort_cell.sv]
// ----------------------------------------------------------------------------
// msort_cell
// One slot of the sorting row: holds one element, makes room for a new
// element by taking its left neighbor's value, and shifts left on drain.
// ----------------------------------------------------------------------------
module msort_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  msort_pkg::cell_ctl_t                ctl,
    input  logic signed [msort_pkg::DATA_W-1:0] left_val,
    input  logic                                left_valid,
    input  logic                                left_gt,
    input  logic signed [msort_pkg::DATA_W-1:0] right_val,
    input  logic                                right_valid,
    output logic signed [msort_pkg::DATA_W-1:0] val,
    output logic                                valid,
    output logic                                gt
);
    import msort_pkg::*;

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic                     valid_reg;
    logic                     valid_next;

    // new element goes at or before this slot
    assign gt = !valid_reg || (val_reg > ctl.din);

    // slot update
    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (gt)
                begin
                    if (left_gt)
                    begin
                        val_next   = left_val;
                        valid_next = left_valid;
                    end
                    else
                    begin
                        val_next   = ctl.din;
                        valid_next = 1'b1;
                    end
                end
            end
            OP_SHIFT:
            begin
                val_next   = right_val;
                valid_next = right_valid;
            end
            default:
            begin
                val_next   = val_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // element payload
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

[rtl/core/merge_sorter_top.sv]
// ----------------------------------------------------------------------------
// merge_sorter_top
// Batch sorter: collects signed elements and returns them in ascending order.
// ----------------------------------------------------------------------------
// Elements are sorted as they arrive by a row of DEPTH cells that keeps the
// stored batch in ascending order: each input request is placed as it is
// taken, the cells at and after its place shifting one slot along the row.
// Input is taken at one request per cycle while a batch is being filled. After
// the request with last_in set, the block stops taking input and sends the
// batch out of the first cell, one result per cycle while not stalled, the row
// shifting toward it. Elements beyond DEPTH are dropped and every result of
// that batch carries overflow. Input is taken again the cycle after the last
// result.
module merge_sorter_top #(
    parameter int DEPTH = msort_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [msort_pkg::DATA_W-1:0] value,
    input  logic                                last_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [msort_pkg::DATA_W-1:0] sorted_value,
    output logic                                last_out,
    output logic                                overflow
);
    import msort_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_FILL,
        S_DRAIN
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               dropped_reg;

    logic               in_acc;
    logic               out_acc;
    logic               has_room;
    cell_ctl_t          ctl;

    logic signed [DATA_W-1:0] cval [DEPTH];
    logic                     cvalid [DEPTH];
    logic                     cgt [DEPTH];

    // handshakes
    assign in_stall  = (state_reg == S_DRAIN);
    assign out_valid = (state_reg == S_DRAIN);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign has_room  = (count_reg < CNT_W'(DEPTH));

    // row control
    always_comb
    begin
        ctl.din = value;
        if (in_acc && has_room)
        begin
            ctl.op = OP_INSERT;
        end
        else if (out_acc)
        begin
            ctl.op = OP_SHIFT;
        end
        else
        begin
            ctl.op = OP_HOLD;
        end
    end

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] lv;
        logic                     lvd;
        logic                     lgt;
        logic signed [DATA_W-1:0] rv;
        logic                     rvd;

        if (i == 0)
        begin : g_first
            assign lv  = '0;
            assign lvd = 1'b0;
            assign lgt = 1'b0;
        end
        else
        begin : g_mid
            assign lv  = cval[i-1];
            assign lvd = cvalid[i-1];
            assign lgt = cgt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign rv  = '0;
            assign rvd = 1'b0;
        end
        else
        begin : g_inner
            assign rv  = cval[i+1];
            assign rvd = cvalid[i+1];
        end

        msort_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_val    (lv),
            .left_valid  (lvd),
            .left_gt     (lgt),
            .right_val   (rv),
            .right_valid (rvd),
            .val         (cval[i]),
            .valid       (cvalid[i]),
            .gt          (cgt[i])
        );
    end

    // batch control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_FILL;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_FILL:
                begin
                    if (in_acc)
                    begin
                        if (has_room)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (last_in)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (out_acc)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            state_reg   <= S_FILL;
                            dropped_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_FILL;
                end
            endcase
        end
    end

    // result fields
    assign sorted_value = cval[0];
    assign last_out     = (count_reg == CNT_W'(1));
    assign overflow     = dropped_reg;

endmodule

[rtl/core/msort_checker.sv]
// ----------------------------------------------------------------------------
// msort_checker
// Port-level checks for the merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
module msort_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                last_in,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [msort_pkg::DATA_W-1:0] sorted_value,
    input  logic                                last_out,
    input  logic                                overflow
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_value)
            && $stable(last_out) && $stable(overflow))
        else $error("stalled result changed");

    // results come out in ascending order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_out |=>
            out_valid && (sorted_value >= $past(sorted_value)))
        else $error("results out of order");

    // no input taken while a batch is sent
    a_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken during drain");

    // end of batch starts the results
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_in |=> out_valid)
        else $error("batch end gave no result");

endmodule

bind merge_sorter_top msort_checker u_msort_checker (.*);

[dv/sorted_batch_check_pkg.sv]
// ----------------------------------------------------------------------------
// sorted_batch_check_pkg
// Tracks each batch that goes into the merge sorter and checks the sorted
// results that come back, field by field, in order.
// ----------------------------------------------------------------------------
package sorted_batch_check_pkg;

    import msort_pkg::DATA_W;

    // one sorted result as the block should deliver it
    typedef struct {
        logic signed [DATA_W-1:0]   sorted_value;
        logic                       last_out;
        logic                       overflow;
    } sorted_result_t;

    class sorted_batch_scoreboard;

        int                         row_depth;
        // elements of the open batch, kept in ascending order as they arrive
        logic signed [DATA_W-1:0]   open_batch[$];
        bit                         open_dropped;
        sorted_result_t             awaited_results[$];
        int                         errors;
        int                         requests;
        int                         results;
        int                         batches;
        int                         overflow_batches;

        function new(int depth_i);
            row_depth = depth_i;
            open_dropped = 1'b0;
            errors = 0;
            requests = 0;
            results = 0;
            batches = 0;
            overflow_batches = 0;
        endfunction

        // accepted input request: store or drop, and release the batch on last
        function void note_request(logic signed [DATA_W-1:0] v, logic last);
            int             pos;
            sorted_result_t r;
            requests++;
            if (open_batch.size() < row_depth)
            begin
                // equal values go after the ones already held
                pos = 0;
                while (pos < open_batch.size() && open_batch[pos] <= v)
                    pos++;
                open_batch.insert(pos, v);
            end
            else
            begin
                open_dropped = 1'b1;
            end
            if (last)
            begin
                foreach (open_batch[k])
                begin
                    r.sorted_value = open_batch[k];
                    r.last_out     = (k == open_batch.size() - 1);
                    r.overflow     = open_dropped;
                    awaited_results.push_back(r);
                end
                batches++;
                if (open_dropped)
                    overflow_batches++;
                open_batch.delete();
                open_dropped = 1'b0;
            end
        endfunction

        // accepted result: compare against the oldest awaited one
        function void check_result(logic signed [DATA_W-1:0] v, logic last, logic ovf);
            sorted_result_t want;
            results++;
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d last_out %0b overflow %0b",
                       v, last, ovf);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (v !== want.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d", want.sorted_value, v);
                errors++;
            end
            if (last !== want.last_out)
            begin
                $error("last_out: expected %0b, got %0b", want.last_out, last);
                errors++;
            end
            if (ovf !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, ovf);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

    endclass

endpackage

[dv/merge_sorter_top_test.sv]
// ----------------------------------------------------------------------------
// merge_sorter_top_test
// Feeds batches of signed elements into the merge sorter, directed ones first
// and then random batches of mixed length, some past the row depth, while
// both handshakes idle and stall at random; every sorted result is checked.
// ----------------------------------------------------------------------------
module merge_sorter_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import msort_pkg::*;
    import sorted_batch_check_pkg::*;

    localparam int ROW = DEPTH_DEFAULT;
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam int RANDOM_REQUESTS = 400;
    localparam int LONG_HOLD_CYCLES = 600;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [DATA_W-1:0]   value = '0;
    logic                       last_in = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [DATA_W-1:0]   sorted_value;
    logic                       last_out;
    logic                       overflow;

    // sender burst state and the receiver's long hold-off request
    int unsigned                burst_left = 0;
    logic                       hold_off_req = 1'b0;
    int                         random_sent = 0;

    sorted_batch_scoreboard     sb = new(ROW);

    merge_sorter_top #(
        .DEPTH(ROW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sorted_value(sorted_value),
        .last_out    (last_out),
        .overflow    (overflow)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("merge_sorter_top regression: fail");
        $finish;
    end

    // handshakes sampled mid-cycle, both settled until the next edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(value, last_in);
            if (out_valid && !out_stall)
                sb.check_result(sorted_value, last_out, overflow);
        end
    end

    // receiver: stall pattern changed by a periodic random pick, plus one long hold-off
    initial
    begin
        int unsigned    pattern;
        int unsigned    cycle;
        int unsigned    hold_left;
        bit             hold_done;
        pattern = 0;
        cycle = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle % 64 == 0)
                pattern = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                case (pattern)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 1);
                    2: out_stall <= cycle[0];
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // random element: full range, clustered duplicates, extremes, near zero
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6: return int'($urandom_range(0, 8)) - 4;
            7: return VAL_MAX - int'($urandom_range(0, 2));
            8: return VAL_MIN + int'($urandom_range(0, 2));
            default: return int'($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    // offer one request and hold it until taken; gaps between random bursts
    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic last);
        int unsigned    gap;
        bit             taken;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        value    <= v;
        last_in  <= last;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_list(input logic signed [DATA_W-1:0] vals[$]);
        foreach (vals[k])
            send_item(vals[k], k == vals.size() - 1);
    endtask

    task automatic send_random_batch(input int len);
        for (int k = 0; k < len; k++)
            send_item(pick_value(), k == len - 1);
        random_sent += len;
    endtask

    // stimulus and end of run
    initial
    begin
        int unsigned    pick;
        int             len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element batches pass straight through, then a pair of extremes
        send_list('{VAL_MAX});
        send_list('{VAL_MIN});
        send_list('{VAL_MAX, VAL_MIN});
        // equal values
        send_list('{5, 5, -5, 5});
        send_list('{0, -1, 1, VAL_MIN, VAL_MAX, -1});
        // descending order in
        send_list('{3, 2, 1, 0, -1, -2});

        // a full row, then the receiver holds off while the next batch is
        // offered, so the input backs up behind the full row
        send_random_batch(ROW);
        hold_off_req <= 1'b1;

        // random batches, mostly short, some full and some past the row
        while (random_sent < RANDOM_REQUESTS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 12);
            else if (pick < 85)
                len = $urandom_range(13, 40);
            else if (pick < 93)
                len = ROW;
            else
                len = ROW + $urandom_range(1, 8);
            send_random_batch(len);
        end
        in_valid <= 1'b0;
        last_in  <= 1'b0;

        // drain, then give any stray result time to show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2 * ROW + 16) @(posedge clk);

        $display("covered %0d batches (%0d past the row depth), %0d requests in, %0d results out",
                 sb.batches, sb.overflow_batches, sb.requests, sb.results);
        $display("mismatches or stray results: %0d", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("merge_sorter_top regression: pass");
        else
            $display("merge_sorter_top regression: fail");
        $finish;
    end

endmodule
